### rtl/qrp_pkg.sv
// ----------------------------------------------------------------------------
// qrp_pkg
// Shared widths, types and register codes for the quaternion point rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package qrp_pkg;

   // Field widths.
   localparam int COORD_WIDTH = 24;
   localparam int QUAT_WIDTH  = 16;

   // Fraction bits of a quaternion component and of a matrix product.
   localparam int QFRAC = QUAT_WIDTH - 2;
   localparam int PFRAC = 2 * QFRAC;

   // Matrix entry: sum of two products, doubled, or sum of four products.
   localparam int MAT_W  = 2 * QUAT_WIDTH + 2;
   // One matrix entry times one coordinate.
   localparam int PROD_W = MAT_W + COORD_WIDTH;
   // Sum of three products plus the rounding constant.
   localparam int ACC_W  = PROD_W + 2;
   // Accumulator after the shift back to coordinate scale.
   localparam int RES_W  = ACC_W - PFRAC;

   // Configuration port.
   localparam int NUM_REGS   = 4;
   localparam int CSR_ADDR_W = $clog2(NUM_REGS) + 2;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);

   // Stream data widths.
   localparam int REQ_DATA_W = 3 * COORD_WIDTH;
   localparam int RSP_DATA_W = 3 * COORD_WIDTH;

   // Pipeline depth of the point path.
   localparam int NUM_STAGES = 5;

   // Quaternion component that stands for 1.0.
   localparam logic [QUAT_WIDTH-1:0] QUAT_ONE =
      {{(QUAT_WIDTH-QFRAC-1){1'b0}}, 1'b1, {QFRAC{1'b0}}};

   // Register codes.
   typedef enum logic [REG_IDX_W-1:0] {
      REG_QUAT_W = 0,
      REG_QUAT_X = 1,
      REG_QUAT_Y = 2,
      REG_QUAT_Z = 3
   } reg_index_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [QUAT_WIDTH-1:0]  quat_type;

   // Rotation matrix, row-major naming.
   typedef struct packed {
      logic signed [MAT_W-1:0] m00;
      logic signed [MAT_W-1:0] m01;
      logic signed [MAT_W-1:0] m02;
      logic signed [MAT_W-1:0] m10;
      logic signed [MAT_W-1:0] m11;
      logic signed [MAT_W-1:0] m12;
      logic signed [MAT_W-1:0] m20;
      logic signed [MAT_W-1:0] m21;
      logic signed [MAT_W-1:0] m22;
   } matrix_type;

endpackage

`default_nettype wire

### rtl/qrp_csr.sv
// ----------------------------------------------------------------------------
// qrp_csr
// Quaternion registers on the APB-style port and the two-stage pipeline that
// turns the quaternion into the rotation matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module qrp_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [qrp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [qrp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [qrp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output qrp_pkg::matrix_type                  matrix
);

   qrp_pkg::quat_type      quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   qrp_pkg::quat_type      quat_w_in, quat_x_in, quat_y_in, quat_z_in;
   qrp_pkg::reg_index_type reg_idx;
   logic                   wr_en;

   logic signed [2*qrp_pkg::QUAT_WIDTH-1:0] ww_in, xx_in, yy_in, zz_in, wx_in;
   logic signed [2*qrp_pkg::QUAT_WIDTH-1:0] wy_in, wz_in, xy_in, xz_in, yz_in;
   logic signed [2*qrp_pkg::QUAT_WIDTH-1:0] ww_ff, xx_ff, yy_ff, zz_ff, wx_ff;
   logic signed [2*qrp_pkg::QUAT_WIDTH-1:0] wy_ff, wz_ff, xy_ff, xz_ff, yz_ff;

   qrp_pkg::matrix_type matrix_in, matrix_ff;

   // Decode of a write transaction; the port never waits.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = qrp_pkg::reg_index_type'(csr_paddr[qrp_pkg::CSR_ADDR_W-1:2]);

   // Next values of the quaternion registers.
   always_comb begin
      quat_w_in = quat_w_ff;
      quat_x_in = quat_x_ff;
      quat_y_in = quat_y_ff;
      quat_z_in = quat_z_ff;
      if (wr_en) begin
         unique case (reg_idx)
            qrp_pkg::REG_QUAT_W: quat_w_in = csr_pwdata[qrp_pkg::QUAT_WIDTH-1:0];
            qrp_pkg::REG_QUAT_X: quat_x_in = csr_pwdata[qrp_pkg::QUAT_WIDTH-1:0];
            qrp_pkg::REG_QUAT_Y: quat_y_in = csr_pwdata[qrp_pkg::QUAT_WIDTH-1:0];
            qrp_pkg::REG_QUAT_Z: quat_z_in = csr_pwdata[qrp_pkg::QUAT_WIDTH-1:0];
            default: quat_w_in = quat_w_ff;
         endcase
      end
   end

   // Quaternion registers reset to the identity rotation.
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff <= qrp_pkg::QUAT_ONE;
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
      end else begin
         quat_w_ff <= quat_w_in;
         quat_x_ff <= quat_x_in;
         quat_y_ff <= quat_y_in;
         quat_z_ff <= quat_z_in;
      end
   end

   // Read back, zero-extended to the bus width.
   always_comb begin
      unique case (reg_idx)
         qrp_pkg::REG_QUAT_W: csr_prdata =
            {{(qrp_pkg::CSR_DATA_W-qrp_pkg::QUAT_WIDTH){1'b0}}, quat_w_ff};
         qrp_pkg::REG_QUAT_X: csr_prdata =
            {{(qrp_pkg::CSR_DATA_W-qrp_pkg::QUAT_WIDTH){1'b0}}, quat_x_ff};
         qrp_pkg::REG_QUAT_Y: csr_prdata =
            {{(qrp_pkg::CSR_DATA_W-qrp_pkg::QUAT_WIDTH){1'b0}}, quat_y_ff};
         qrp_pkg::REG_QUAT_Z: csr_prdata =
            {{(qrp_pkg::CSR_DATA_W-qrp_pkg::QUAT_WIDTH){1'b0}}, quat_z_ff};
         default: csr_prdata = '0;
      endcase
   end

   // First matrix stage: the ten component products.
   assign ww_in = quat_w_ff * quat_w_ff;
   assign xx_in = quat_x_ff * quat_x_ff;
   assign yy_in = quat_y_ff * quat_y_ff;
   assign zz_in = quat_z_ff * quat_z_ff;
   assign wx_in = quat_w_ff * quat_x_ff;
   assign wy_in = quat_w_ff * quat_y_ff;
   assign wz_in = quat_w_ff * quat_z_ff;
   assign xy_in = quat_x_ff * quat_y_ff;
   assign xz_in = quat_x_ff * quat_z_ff;
   assign yz_in = quat_y_ff * quat_z_ff;

   always_ff @(posedge clock) begin
      ww_ff <= ww_in;
      xx_ff <= xx_in;
      yy_ff <= yy_in;
      zz_ff <= zz_in;
      wx_ff <= wx_in;
      wy_ff <= wy_in;
      wz_ff <= wz_in;
      xy_ff <= xy_in;
      xz_ff <= xz_in;
      yz_ff <= yz_in;
   end

   // Second matrix stage: diagonal sums and doubled off-diagonal terms.
   always_comb begin
      matrix_in.m00 = qrp_pkg::MAT_W'(ww_ff) + qrp_pkg::MAT_W'(xx_ff)
                    - qrp_pkg::MAT_W'(yy_ff) - qrp_pkg::MAT_W'(zz_ff);
      matrix_in.m11 = qrp_pkg::MAT_W'(ww_ff) - qrp_pkg::MAT_W'(xx_ff)
                    + qrp_pkg::MAT_W'(yy_ff) - qrp_pkg::MAT_W'(zz_ff);
      matrix_in.m22 = qrp_pkg::MAT_W'(ww_ff) - qrp_pkg::MAT_W'(xx_ff)
                    - qrp_pkg::MAT_W'(yy_ff) + qrp_pkg::MAT_W'(zz_ff);
      matrix_in.m01 = (qrp_pkg::MAT_W'(xy_ff) - qrp_pkg::MAT_W'(wz_ff)) <<< 1;
      matrix_in.m02 = (qrp_pkg::MAT_W'(xz_ff) + qrp_pkg::MAT_W'(wy_ff)) <<< 1;
      matrix_in.m10 = (qrp_pkg::MAT_W'(xy_ff) + qrp_pkg::MAT_W'(wz_ff)) <<< 1;
      matrix_in.m12 = (qrp_pkg::MAT_W'(yz_ff) - qrp_pkg::MAT_W'(wx_ff)) <<< 1;
      matrix_in.m20 = (qrp_pkg::MAT_W'(xz_ff) - qrp_pkg::MAT_W'(wy_ff)) <<< 1;
      matrix_in.m21 = (qrp_pkg::MAT_W'(yz_ff) + qrp_pkg::MAT_W'(wx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      matrix_ff <= matrix_in;
   end

   assign matrix = matrix_ff;

endmodule

`default_nettype wire

### rtl/qrp_datapath.sv
// ----------------------------------------------------------------------------
// qrp_datapath
// Five-stage point pipeline: input register, delay, nine products, row sums
// with rounding, shift and saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qrp_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire qrp_pkg::matrix_type             matrix,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [qrp_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [qrp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                 rsp_tuser
);

   localparam int CW = qrp_pkg::COORD_WIDTH;

   localparam logic signed [qrp_pkg::ACC_W-1:0] ROUND_HALF =
      qrp_pkg::ACC_W'(1) <<< (qrp_pkg::PFRAC - 1);
   localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

   logic [qrp_pkg::NUM_STAGES-1:0] stg_valid_ff, stg_valid_in, stg_ready, stg_feed;

   qrp_pkg::coord_type px0_ff, py0_ff, pz0_ff;
   qrp_pkg::coord_type px1_ff, py1_ff, pz1_ff;

   logic signed [qrp_pkg::PROD_W-1:0] prod_in [0:8];
   logic signed [qrp_pkg::PROD_W-1:0] prod_ff [0:8];

   logic signed [qrp_pkg::ACC_W-1:0] acc_in [0:2];
   logic signed [qrp_pkg::ACC_W-1:0] acc_ff [0:2];

   logic [CW-1:0] rot_in [0:2];
   logic [CW-1:0] rot_ff [0:2];
   logic [2:0]    ovf;
   logic          clip_in, clip_ff;

   // Saturate a shifted sum to the coordinate range; top bit flags a clamp.
   function automatic logic [CW:0] saturate(input logic [qrp_pkg::RES_W-1:0] res);
      logic [qrp_pkg::RES_W-CW:0] upper;
      logic                       over;
      upper = res[qrp_pkg::RES_W-1:CW-1];
      over  = !((&upper) || !(|upper));
      if (!over) begin
         saturate = {1'b0, res[CW-1:0]};
      end else if (res[qrp_pkg::RES_W-1]) begin
         saturate = {1'b1, COORD_MIN};
      end else begin
         saturate = {1'b1, COORD_MAX};
      end
   endfunction

   // Each stage loads when it is empty or its content moves on.
   always_comb begin
      stg_ready[qrp_pkg::NUM_STAGES-1] =
         !stg_valid_ff[qrp_pkg::NUM_STAGES-1] || rsp_tready;
      for (int k = qrp_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         stg_ready[k] = !stg_valid_ff[k] || stg_ready[k+1];
      end
      stg_feed = {stg_valid_ff[qrp_pkg::NUM_STAGES-2:0], req_tvalid};
      for (int k = 0; k < qrp_pkg::NUM_STAGES; k++) begin
         stg_valid_in[k] = stg_ready[k] ? stg_feed[k] : stg_valid_ff[k];
      end
   end

   assign req_tready = stg_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   // Stages 0 and 1: capture the point and give the matrix time to settle.
   always_ff @(posedge clock) begin
      if (stg_ready[0]) begin
         px0_ff <= req_tdata[CW-1:0];
         py0_ff <= req_tdata[2*CW-1:CW];
         pz0_ff <= req_tdata[3*CW-1:2*CW];
      end
      if (stg_ready[1]) begin
         px1_ff <= px0_ff;
         py1_ff <= py0_ff;
         pz1_ff <= pz0_ff;
      end
   end

   // Stage 2: the nine matrix-by-coordinate products.
   always_comb begin
      prod_in[0] = $signed(matrix.m00) * px1_ff;
      prod_in[1] = $signed(matrix.m01) * py1_ff;
      prod_in[2] = $signed(matrix.m02) * pz1_ff;
      prod_in[3] = $signed(matrix.m10) * px1_ff;
      prod_in[4] = $signed(matrix.m11) * py1_ff;
      prod_in[5] = $signed(matrix.m12) * pz1_ff;
      prod_in[6] = $signed(matrix.m20) * px1_ff;
      prod_in[7] = $signed(matrix.m21) * py1_ff;
      prod_in[8] = $signed(matrix.m22) * pz1_ff;
   end

   always_ff @(posedge clock) begin
      if (stg_ready[2]) begin
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   // Stage 3: row sums with the half-step added for round-half-up.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = qrp_pkg::ACC_W'(prod_ff[3*r]) + qrp_pkg::ACC_W'(prod_ff[3*r+1])
                   + qrp_pkg::ACC_W'(prod_ff[3*r+2]) + ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[3]) begin
         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= acc_in[r];
         end
      end
   end

   // Stage 4: drop the fraction bits (floor) and clamp each coordinate.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         {ovf[r], rot_in[r]} = saturate(acc_ff[r][qrp_pkg::ACC_W-1:qrp_pkg::PFRAC]);
      end
      clip_in = |ovf;
   end

   always_ff @(posedge clock) begin
      if (stg_ready[4]) begin
         for (int r = 0; r < 3; r++) begin
            rot_ff[r] <= rot_in[r];
         end
         clip_ff <= clip_in;
      end
   end

   assign rsp_tvalid = stg_valid_ff[qrp_pkg::NUM_STAGES-1];
   assign rsp_tdata  = {rot_ff[2], rot_ff[1], rot_ff[0]};
   assign rsp_tuser  = clip_ff;

   // An accepted transaction always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> stg_valid_ff[0])
      else $error("accepted transaction missing from stage 0");

   // A product stage blocked by a full successor keeps its item and data.
   assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff[2] && !stg_ready[3] |=> stg_valid_ff[2] && $stable(prod_ff[0]))
      else $error("stalled product stage lost its contents");

   // The clip flag only comes with a coordinate at one of the rails.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rot_ff[0] == COORD_MAX || rot_ff[0] == COORD_MIN ||
         rot_ff[1] == COORD_MAX || rot_ff[1] == COORD_MIN ||
         rot_ff[2] == COORD_MAX || rot_ff[2] == COORD_MIN)
      else $error("clip flag set without a saturated coordinate");

endmodule

`default_nettype wire

### rtl/quaternion_rotate_point_unit.sv
// ----------------------------------------------------------------------------
// quaternion_rotate_point_unit
// Rotates a stream of 3-D points by the quaternion held in its registers.
// ----------------------------------------------------------------------------
//
//   Channel   Ports   Width  Contents (low bit first)
//   request   req_*   72     tdata: point_x, point_y, point_z
//   response  rsp_*   72+1   tdata: rot_x, rot_y, rot_z; tuser: clipped
//   control   csr_*   32     quat_w at 0x0, quat_x at 0x4, quat_y at 0x8, quat_z at 0xC
//
// One point per cycle while the response is not stalled; a result is offered when
// its transaction reaches the last of the five register stages of the point pipeline
// (capture, delay, products, sums, clamp); the first loads at the accepting edge.
// Reset clears all stage valid bits and loads the identity quaternion.
// A register write passes through the product and matrix registers to the matrix
// before any point accepted afterwards reaches the multipliers.
// A stalled response holds each stage that is full; empty stages keep filling.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_rotate_point_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Point input: point_x, point_y, point_z.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [qrp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Rotated point: rot_x, rot_y, rot_z.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [qrp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Result flag: clipped.
   output logic                                 rsp_tuser,
   // Register port.
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [qrp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [qrp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [qrp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   qrp_pkg::matrix_type matrix;

   // Registers and rotation matrix.
   qrp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .matrix      (matrix)
   );

   // Point pipeline.
   qrp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .matrix     (matrix),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
